/* src/tps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg: shared types and tables of the tone pattern sequencer
// Holds the input word type, the step type and the constant pattern table.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned ClockHz   = 125000000;
  localparam logic [15:0] WrapMax   = 16'd65535;
  localparam int unsigned PatCount  = 8;
  localparam int unsigned SlotCount = 16;

  localparam logic KindPoll  = 1'b0;
  localparam logic KindStart = 1'b1;

  // PWM period counts for each tone used in the table, saturated at WrapMax.
  localparam logic [15:0] Wrap400  = (ClockHz / 400  > 65535) ? WrapMax : 16'(ClockHz / 400);
  localparam logic [15:0] Wrap523  = (ClockHz / 523  > 65535) ? WrapMax : 16'(ClockHz / 523);
  localparam logic [15:0] Wrap659  = (ClockHz / 659  > 65535) ? WrapMax : 16'(ClockHz / 659);
  localparam logic [15:0] Wrap784  = (ClockHz / 784  > 65535) ? WrapMax : 16'(ClockHz / 784);
  localparam logic [15:0] Wrap800  = (ClockHz / 800  > 65535) ? WrapMax : 16'(ClockHz / 800);
  localparam logic [15:0] Wrap1000 = (ClockHz / 1000 > 65535) ? WrapMax : 16'(ClockHz / 1000);
  localparam logic [15:0] Wrap1047 = (ClockHz / 1047 > 65535) ? WrapMax : 16'(ClockHz / 1047);
  localparam logic [15:0] Wrap1200 = (ClockHz / 1200 > 65535) ? WrapMax : 16'(ClockHz / 1200);
  localparam logic [15:0] Wrap1500 = (ClockHz / 1500 > 65535) ? WrapMax : 16'(ClockHz / 1500);
  localparam logic [15:0] Wrap2000 = (ClockHz / 2000 > 65535) ? WrapMax : 16'(ClockHz / 2000);

  typedef struct packed {
    logic        kind;
    logic [7:0]  pattern;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        tone;  // frequency is nonzero
    logic        term;  // zero-zero terminator
    logic [15:0] wrap;
    logic [15:0] ms;
  } step_t;

  function automatic step_t mk_step(logic [15:0] hz, logic [15:0] wrap, logic [15:0] ms);
    step_t st;
    st.tone = (hz != 16'd0);
    st.term = (hz == 16'd0) && (ms == 16'd0);
    st.wrap = wrap;
    st.ms   = ms;
    return st;
  endfunction

  // Pattern table; every slot not listed is a terminator.
  function automatic step_t step_lookup(logic [2:0] pat, logic [3:0] slot);
    step_t st;
    st = mk_step(16'd0, 16'd0, 16'd0);
    case ({pat, slot})
      {3'd0, 4'd0}: st = mk_step(16'd1000, Wrap1000, 16'd100);
      {3'd0, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd100);
      {3'd0, 4'd2}: st = mk_step(16'd1000, Wrap1000, 16'd100);
      {3'd0, 4'd3}: st = mk_step(16'd0,    16'd0,    16'd100);
      {3'd0, 4'd4}: st = mk_step(16'd1000, Wrap1000, 16'd100);
      {3'd1, 4'd0}: st = mk_step(16'd800,  Wrap800,  16'd150);
      {3'd1, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd50);
      {3'd1, 4'd2}: st = mk_step(16'd1200, Wrap1200, 16'd150);
      {3'd2, 4'd0}: st = mk_step(16'd1200, Wrap1200, 16'd150);
      {3'd2, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd50);
      {3'd2, 4'd2}: st = mk_step(16'd800,  Wrap800,  16'd150);
      {3'd3, 4'd0}: st = mk_step(16'd1500, Wrap1500, 16'd80);
      {3'd4, 4'd0}: st = mk_step(16'd400,  Wrap400,  16'd500);
      {3'd5, 4'd0}: st = mk_step(16'd523,  Wrap523,  16'd80);
      {3'd5, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd5, 4'd2}: st = mk_step(16'd659,  Wrap659,  16'd80);
      {3'd5, 4'd3}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd5, 4'd4}: st = mk_step(16'd784,  Wrap784,  16'd80);
      {3'd6, 4'd0}: st = mk_step(16'd2000, Wrap2000, 16'd60);
      {3'd6, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd40);
      {3'd6, 4'd2}: st = mk_step(16'd2000, Wrap2000, 16'd60);
      {3'd7, 4'd0}: st = mk_step(16'd523,  Wrap523,  16'd80);
      {3'd7, 4'd1}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd7, 4'd2}: st = mk_step(16'd659,  Wrap659,  16'd80);
      {3'd7, 4'd3}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd7, 4'd4}: st = mk_step(16'd784,  Wrap784,  16'd80);
      {3'd7, 4'd5}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd7, 4'd6}: st = mk_step(16'd1047, Wrap1047, 16'd80);
      {3'd7, 4'd7}: st = mk_step(16'd0,    16'd0,    16'd30);
      {3'd7, 4'd8}: st = mk_step(16'd784,  Wrap784,  16'd80);
      default:      st = mk_step(16'd0,    16'd0,    16'd0);
    endcase
    return st;
  endfunction

endpackage

/* src/tone_pattern_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_pattern_sequencer_core: buzzer tone pattern sequencer
// Plays one of eight built-in tone patterns and reports the PWM setup.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Word contents
//   -------  ---------  -------------------  ------------------------------------
//   in       input      in_valid/in_stall    kind, pattern, now_ms
//   out      output     out_valid/out_stall  tone_on, pwm_wrap, pwm_level,
//                                            playing, step_index
//
// Every input word gives exactly one output word. An accepted word sits in
// the input register while the step engine works on it, and the result is
// registered in the engine state registers, which form the output word.
// A new word may be accepted every cycle while out_stall is low; throughput
// is then one word per cycle.
// Reset (rst, synchronous) clears the pipeline and sets the playback state
// to idle with tone off, wrap 0 and step 0.
// While out_stall is high the output word holds and the input register
// fills, after which in_stall rises until the output side drains.
//
module tone_pattern_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  pattern,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tone_on,
  output logic [15:0] pwm_wrap,
  output logic [14:0] pwm_level,
  output logic        playing,
  output logic [3:0]  step_index
);
  import tps_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  take;

  // Pack the input fields into one word for the input register.
  assign in_item.kind    = kind;
  assign in_item.pattern = pattern;
  assign in_item.now_ms  = now_ms;

  tps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // The engine owns the playback state; its registers are the output word.
  tps_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tone_on    (tone_on),
    .pwm_wrap   (pwm_wrap),
    .pwm_level  (pwm_level),
    .playing    (playing),
    .step_index (step_index)
  );

endmodule

/* src/tps_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_in_reg: input word register
// Captures one input word and holds it until the step engine takes it.
// ----------------------------------------------------------------------------
module tps_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tps_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output tps_pkg::item_t item
);
  import tps_pkg::*;

  logic load;

  // The register frees up in the same cycle that the engine takes its word.
  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

/* src/tps_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_engine: sequencer state and result register
// Applies one start or poll word to the playback state per cycle while the output side is not stalled.
// ----------------------------------------------------------------------------
module tps_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  tps_pkg::item_t item,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           tone_on,
  output logic [15:0]    pwm_wrap,
  output logic [14:0]    pwm_level,
  output logic           playing,
  output logic [3:0]     step_index
);
  import tps_pkg::*;

  logic        active, active_next;
  logic [2:0]  current_pattern, current_pattern_next;
  logic [3:0]  step_count, step_count_next;
  logic [31:0] step_end_time, step_end_time_next;
  logic        tone_enabled, tone_enabled_next;
  logic [15:0] wrap_value, wrap_value_next;

  logic        start_ok;
  logic        due;
  logic [2:0]  sel_pat;
  logic [3:0]  sel_slot;
  step_t       st;

  // The state registers double as the result register: they only change
  // when the output side is free, so a stalled result holds.
  assign take = item_valid && (!out_valid || !out_stall);

  assign start_ok = (item.pattern >= 8'd1) && (item.pattern <= 8'(PatCount));
  assign due      = active && (item.now_ms >= step_end_time);

  always_comb begin
    if (item.kind == KindStart) begin
      sel_pat  = 3'(item.pattern - 8'd1);
      sel_slot = 4'd0;
    end else begin
      sel_pat  = current_pattern;
      sel_slot = step_count + 4'd1;
    end
    st = step_lookup(sel_pat, sel_slot);
  end

  always_comb begin
    active_next          = active;
    current_pattern_next = current_pattern;
    step_count_next      = step_count;
    step_end_time_next   = step_end_time;
    tone_enabled_next    = tone_enabled;
    wrap_value_next      = wrap_value;
    if (item.kind == KindStart) begin
      if (start_ok) begin
        current_pattern_next = sel_pat;
        step_count_next      = 4'd0;
        active_next          = 1'b1;
        tone_enabled_next    = st.tone;
        if (st.tone) begin
          wrap_value_next = st.wrap;
        end
        step_end_time_next = item.now_ms + {16'd0, st.ms};
      end
    end else if (due) begin
      step_count_next = sel_slot;
      if (st.term) begin
        tone_enabled_next = 1'b0;
        active_next       = 1'b0;
      end else begin
        tone_enabled_next = st.tone;
        if (st.tone) begin
          wrap_value_next = st.wrap;
        end
        step_end_time_next = item.now_ms + {16'd0, st.ms};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      active          <= 1'b0;
      current_pattern <= 3'd0;
      step_count      <= 4'd0;
      step_end_time   <= 32'd0;
      tone_enabled    <= 1'b0;
      wrap_value      <= 16'd0;
    end else begin
      if (take) begin
        out_valid       <= 1'b1;
        active          <= active_next;
        current_pattern <= current_pattern_next;
        step_count      <= step_count_next;
        step_end_time   <= step_end_time_next;
        tone_enabled    <= tone_enabled_next;
        wrap_value      <= wrap_value_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tone_on    = tone_enabled;
  assign pwm_wrap   = wrap_value;
  assign pwm_level  = wrap_value[15:1];
  assign playing    = active;
  assign step_index = step_count;

endmodule

/* src/tps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_checker: port-level checks of the tone pattern sequencer
// Watches the top-level ports and flags illegal output words.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        tone_on,
  input logic [15:0] pwm_wrap,
  input logic [14:0] pwm_level,
  input logic        playing,
  input logic [3:0]  step_index
);
  import tps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pwm_wrap) && $stable(step_index)
      && $stable(tone_on) && $stable(playing))
    else $error("output word changed while stalled");

  a_level_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pwm_level == pwm_wrap[15:1])
    else $error("pwm_level is not half of pwm_wrap");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !playing |-> !tone_on)
    else $error("tone on while no pattern plays");

  a_wrap_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_on |-> pwm_wrap == WrapMax || pwm_wrap == Wrap2000)
    else $error("tone on with a wrap not in the table");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_index <= 4'd9)
    else $error("step index past the longest pattern");

endmodule

bind tone_pattern_sequencer_core tps_checker u_tps_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tone_on    (tone_on),
  .pwm_wrap   (pwm_wrap),
  .pwm_level  (pwm_level),
  .playing    (playing),
  .step_index (step_index)
);
